[design/cnsp_pkg.sv]
// cnsp_pkg: constants of the cpio newc header layout and the trailer name
// used by the stream parser; no dependencies
`default_nettype none

package cnsp_pkg;

   localparam int unsigned HDR_LEN    = 110;
   localparam int unsigned FSIZE_AT   = 54;
   localparam int unsigned NSIZE_AT   = 94;
   localparam int unsigned HEX_DIGITS = 8;
   localparam int unsigned TRL_LEN    = 10;

   localparam int unsigned FSIZE_END = FSIZE_AT + HEX_DIGITS;
   localparam int unsigned NSIZE_END = NSIZE_AT + HEX_DIGITS;
   localparam int unsigned FSIZE_TOP = FSIZE_END - 1;
   localparam int unsigned NSIZE_TOP = NSIZE_END - 1;

   // characters of "TRAILER!!!"
   function automatic logic [7:0] trl_char(input logic [3:0] pos);
      logic [7:0] ch;
      case (pos)
         4'd0: ch = 8'h54;
         4'd1: ch = 8'h52;
         4'd2: ch = 8'h41;
         4'd3: ch = 8'h49;
         4'd4: ch = 8'h4c;
         4'd5: ch = 8'h45;
         4'd6: ch = 8'h52;
         4'd7: ch = 8'h21;
         4'd8: ch = 8'h21;
         4'd9: ch = 8'h21;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

[design/cnsp_ifs.sv]
// cnsp_req_if / cnsp_rsp_if: valid/ready channels of the cpio newc parser
// no dependencies
`default_nettype none

interface cnsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] archive_byte;

   modport source (output valid, output archive_byte, input ready);
   modport sink (input valid, input archive_byte, output ready);
endinterface

interface cnsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic [2:0]  region;
   logic        entry_last;
   logic        is_trailer;
   logic [31:0] content_size;
   logic [31:0] name_length;

   modport source (output valid, output data_byte, output region, output entry_last,
                   output is_trailer, output content_size, output name_length,
                   input ready);
   modport sink (input valid, input data_byte, input region, input entry_last,
                 input is_trailer, input content_size, input name_length,
                 output ready);
endinterface

`default_nettype wire

[design/cpio_newc_stream_parser.sv]
// cpio_newc_stream_parser: tags each byte of a cpio newc archive with its region
// depends on cnsp_pkg and the channel interfaces in cnsp_ifs.sv
//
// usage
//   req_bus carries one archive byte per beat; rsp_bus returns one tagged beat
//   for every accepted byte: the byte itself, its region (header, name, name
//   pad, content, content pad, past end), an end-of-entry mark, the trailer
//   flag and the decoded file and name sizes of the current entry
//   the header's size fields are decoded as their digits stream past
//   a registered result shows on rsp_bus the cycle after its byte is taken
//   throughput: one byte per cycle while rsp_bus.ready is high; all per-byte
//   work (counter step, hex digit accumulate, region length compare) sits
//   between the parser state and the result register
//   stall: the result register holds while rsp_bus.ready is low; a new byte
//   is still taken in the cycle the held result is drained
//   reset: synchronous; the parser returns to the first header byte of the
//   archive, sizes cleared, no result pending
//   after the trailer entry every byte is tagged past end until reset
`default_nettype none

module cpio_newc_stream_parser
   import cnsp_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   cnsp_req_if.sink    req_bus,
   cnsp_rsp_if.source  rsp_bus
);

   typedef enum logic [2:0] {
      PH_HEADER  = 3'd0,
      PH_NAME    = 3'd1,
      PH_NAMEPAD = 3'd2,
      PH_CONTENT = 3'd3,
      PH_CONTPAD = 3'd4,
      PH_END     = 3'd5
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [31:0] count_ff, count_in;
   logic [31:0] accum_ff, accum_in;
   logic [31:0] csize_ff, csize_in;
   logic [31:0] nsize_ff, nsize_in;
   logic        stop_ff, stop_in;
   logic        match_ff, match_in;

   logic        rsp_valid_ff;
   logic [7:0]  rsp_byte_ff;
   logic [2:0]  rsp_region_ff;
   logic        rsp_last_ff, rsp_last_in;
   logic        rsp_trl_ff, rsp_trl_in;
   logic [31:0] rsp_csize_ff;
   logic [31:0] rsp_nsize_ff;

   logic        accept;
   logic [7:0]  in_byte;
   logic [31:0] count_plus;
   logic [31:0] cur_len;
   logic [1:0]  npad_len;
   logic [1:0]  cpad_len;
   logic [4:0]  len_nz;
   logic        digit_ok;
   logic [3:0]  digit_val;
   logic        in_field;
   logic        field_start;
   logic [31:0] accum_base;
   logic        stop_base;
   logic        matched;
   logic        found;
   phase_type   next_phase;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;
   assign in_byte       = req_bus.archive_byte;

   // hex digit decode
   always_comb begin
      digit_ok  = 1'b1;
      digit_val = 4'd0;
      if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
         digit_val = in_byte[3:0];
      end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                   (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
         digit_val = 4'(in_byte[2:0] + 3'd1) + 4'd8;
      end else begin
         digit_ok = 1'b0;
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      accum_in    = accum_ff;
      csize_in    = csize_ff;
      nsize_in    = nsize_ff;
      stop_in     = stop_ff;
      match_in    = match_ff;
      rsp_last_in = 1'b0;
      rsp_trl_in  = 1'b0;
      accum_base  = accum_ff;
      stop_base   = stop_ff;
      in_field    = 1'b0;
      field_start = 1'b0;
      matched     = 1'b0;
      found       = 1'b0;
      next_phase  = PH_HEADER;
      count_plus  = count_ff + 32'd1;
      npad_len    = 2'd0;
      cpad_len    = 2'd0;
      len_nz      = 5'd0;
      cur_len     = 32'd0;

      if (phase_ff == PH_END) begin
         rsp_trl_in = 1'b1;
      end else begin
         if (phase_ff == PH_HEADER) begin
            if (count_ff == 32'd0) begin
               csize_in = 32'd0;
               nsize_in = 32'd0;
               match_in = 1'b1;
            end
            in_field = (count_ff >= FSIZE_AT && count_ff < FSIZE_END) ||
                       (count_ff >= NSIZE_AT && count_ff < NSIZE_END);
            field_start = (count_ff == FSIZE_AT) || (count_ff == NSIZE_AT);
            if (in_field) begin
               if (field_start) begin
                  accum_base = 32'd0;
                  stop_base  = 1'b0;
               end
               accum_in = accum_base;
               stop_in  = stop_base;
               if (!stop_base) begin
                  if (digit_ok) begin
                     accum_in = {accum_base[27:0], digit_val};
                  end else begin
                     stop_in = 1'b1;
                  end
               end
               if (count_ff == FSIZE_TOP) begin
                  csize_in = accum_in;
               end
               if (count_ff == NSIZE_TOP) begin
                  nsize_in = accum_in;
               end
            end
         end else if (phase_ff == PH_NAME) begin
            if (count_ff < TRL_LEN) begin
               if (in_byte != trl_char(count_ff[3:0])) begin
                  match_in = 1'b0;
               end
            end else if (count_ff == TRL_LEN) begin
               if (in_byte != 8'h00) begin
                  match_in = 1'b0;
               end
            end
         end

         matched = match_in && (nsize_in >= TRL_LEN);
         if (matched && ((phase_ff != PH_HEADER && phase_ff != PH_NAME) ||
                         (phase_ff == PH_NAME && count_plus == nsize_in))) begin
            rsp_trl_in = 1'b1;
         end

         npad_len = 2'd0 - (nsize_in[1:0] + 2'd2);
         cpad_len = 2'd0 - csize_in[1:0];
         len_nz   = {cpad_len != 2'd0, csize_in != 32'd0, npad_len != 2'd0,
                     nsize_in != 32'd0, 1'b1};

         case (phase_ff)
            PH_HEADER:  cur_len = 32'(HDR_LEN);
            PH_NAME:    cur_len = nsize_in;
            PH_NAMEPAD: cur_len = {30'd0, npad_len};
            PH_CONTENT: cur_len = csize_in;
            PH_CONTPAD: cur_len = {30'd0, cpad_len};
            default:    cur_len = 32'd0;
         endcase

         // first non-empty region after the current one
         for (int k = 4; k >= 1; k--) begin
            if (len_nz[k] && (3'(k) > phase_ff)) begin
               next_phase = phase_type'(3'(k));
               found      = 1'b1;
            end
         end

         if (count_plus >= cur_len) begin
            count_in = 32'd0;
            if (found) begin
               phase_in = next_phase;
            end else begin
               rsp_last_in = 1'b1;
               phase_in    = matched ? PH_END : PH_HEADER;
            end
         end else begin
            count_in = count_plus;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         count_ff     <= 32'd0;
         accum_ff     <= 32'd0;
         csize_ff     <= 32'd0;
         nsize_ff     <= 32'd0;
         stop_ff      <= 1'b0;
         match_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff      <= phase_in;
            count_ff      <= count_in;
            accum_ff      <= accum_in;
            csize_ff      <= csize_in;
            nsize_ff      <= nsize_in;
            stop_ff       <= stop_in;
            match_ff      <= match_in;
            rsp_valid_ff  <= 1'b1;
            rsp_byte_ff   <= in_byte;
            rsp_region_ff <= phase_ff;
            rsp_last_ff   <= rsp_last_in;
            rsp_trl_ff    <= rsp_trl_in;
            rsp_csize_ff  <= csize_in;
            rsp_nsize_ff  <= nsize_in;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.data_byte    = rsp_byte_ff;
   assign rsp_bus.region       = rsp_region_ff;
   assign rsp_bus.entry_last   = rsp_last_ff;
   assign rsp_bus.is_trailer   = rsp_trl_ff;
   assign rsp_bus.content_size = rsp_csize_ff;
   assign rsp_bus.name_length  = rsp_nsize_ff;

endmodule

`default_nettype wire
